// ===== hdl/rrsd_pkg.sv =====
// ---------------------------------------------------------------------------
// rrsd_pkg: shared types and constants of the ring route SCAN dispatcher
// Field widths, run mode codes, request kinds and CSR indexes.
// ---------------------------------------------------------------------------
package rrsd_pkg;

   localparam int MAX_STATIONS = 16;
   localparam int MAX_SPACING  = 16;

   localparam int REQ_TYPE_W   = 2;
   localparam int STATION_W    = 5;
   localparam int TICKS_W      = 32;
   localparam int POS_W        = 8;
   localparam int MODE_W       = 2;
   localparam int MASK_W       = 16;
   localparam int CSR_DATA_W   = 5;
   localparam int CSR_INDEX_W  = 1;

   // run modes
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INC  = 2'd3;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CCW  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CW   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP = 2'd3;

   // CSR indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_STATIONS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_SPACING = 1'b1;

   localparam logic [CSR_DATA_W-1:0] NUM_STATIONS_RST = 5'd5;
   localparam logic [CSR_DATA_W-1:0] STOP_SPACING_RST = 5'd2;

endpackage

// ===== hdl/rrsd_req_if.sv =====
// ---------------------------------------------------------------------------
// rrsd_req_if: request channel of the ring route SCAN dispatcher
// Valid/ready handshake carrying one tick or call request.
// ---------------------------------------------------------------------------
interface rrsd_req_if;
   logic                               valid;
   logic                               ready;
   logic [rrsd_pkg::REQ_TYPE_W-1:0]    req_type;
   logic [rrsd_pkg::STATION_W-1:0]     station_id;

   modport source (output valid, output req_type, output station_id, input ready);
   modport sink   (input valid, input req_type, input station_id, output ready);
endinterface

// ===== hdl/rrsd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rrsd_rsp_if: status channel of the ring route SCAN dispatcher
// Valid/ready handshake carrying one status snapshot per request.
// ---------------------------------------------------------------------------
interface rrsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rrsd_pkg::TICKS_W-1:0]       out_ticks;
   logic [rrsd_pkg::POS_W-1:0]         out_position;
   logic [rrsd_pkg::MODE_W-1:0]        out_mode;
   logic [rrsd_pkg::STATION_W-1:0]     out_goal;
   logic [rrsd_pkg::MASK_W-1:0]        out_stop_mask;
   logic [rrsd_pkg::MASK_W-1:0]        out_cw_mask;
   logic [rrsd_pkg::MASK_W-1:0]        out_ccw_mask;

   modport source (output valid, output out_ticks, output out_position, output out_mode,
                   output out_goal, output out_stop_mask, output out_cw_mask,
                   output out_ccw_mask, input ready);
   modport sink   (input valid, input out_ticks, input out_position, input out_mode,
                   input out_goal, input out_stop_mask, input out_cw_mask,
                   input out_ccw_mask, output ready);
endinterface

// ===== hdl/ring_route_scan_dispatcher_unit.sv =====
// Sequence per request: an 8-step restoring division of the position, then execute;
//   a tick may add the goal search (up to n/2 nearest pairs when idle; from a stop a
//   sweep of up to n stations first), then the status loads.
// Requests: one at a time, ready again in the cycle after the status loads.
// Reset (synchronous, active high) clears the sequencer, vehicle state, call masks and
//   status valid, and sets 5 stations at spacing 2.
// ---------------------------------------------------------------------------
// ring_route_scan_dispatcher_unit: SCAN dispatcher for one vehicle on a ring
// Sequencer around a shared divider / station walker; one status per request.
// ---------------------------------------------------------------------------
module ring_route_scan_dispatcher_unit (
   input  logic                               clock,
   input  logic                               reset,
   rrsd_req_if.sink                           req_chan,
   rrsd_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [rrsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rrsd_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DIV    = 8'b0000_0010,
      S_EXEC   = 8'b0000_0100,
      S_CHOOSE = 8'b0000_1000,
      S_SCAN   = 8'b0001_0000,
      S_NEAR   = 8'b0010_0000,
      S_DIRSET = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;

   logic [4:0]  num_ff, spc_ff;
   logic [31:0] ticks_ff, ticks_in;
   logic [7:0]  pos_ff, pos_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  prior_ff, prior_in;
   logic [4:0]  goal_ff, goal_in;
   logic [15:0] cw_ff, cw_in, ccw_ff, ccw_in, stop_ff, stop_in;

   logic [1:0]  kind_ff, kind_in;
   logic [4:0]  sid_ff, sid_in;
   logic [7:0]  quo_ff, quo_in;
   logic [4:0]  rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        path_ff, path_in;   // 1: search entered from a stop at the goal
   logic [4:0]  t_ff, t_in;
   logic [4:0]  k_ff, k_in;
   logic [3:0]  d_ff, d_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;

   logic [31:0] rsp_ticks_ff;
   logic [7:0]  rsp_pos_ff;
   logic [1:0]  rsp_mode_ff;
   logic [4:0]  rsp_goal_ff;
   logic [15:0] rsp_stop_ff, rsp_cw_ff, rsp_ccw_ff;

   logic [4:0]  nc, spc, half_n, st;
   logic [9:0]  len_full;
   logic [8:0]  len;
   logic [15:0] pend_mask, ring_mask;
   logic [16:0] ring_mask_w;
   logic        any_pend;

   // shared divider step
   logic [5:0]  div_cand;
   logic        div_bit;

   // move unit
   logic [1:0]  mv_dir;
   logic [7:0]  mv_pos;
   logic [7:0]  mv_quo;
   logic [4:0]  mv_rem;
   logic        mv_park;

   // walker
   logic [4:0]  t_nx;
   logic [5:0]  a_sum, b_sum, a_red, b_red;
   logic [4:0]  a_st, b_st;

   // half-ring direction
   logic [5:0]  e_sum, e_red;
   logic [4:0]  e_st;
   logic        cw_half;
   logic [1:0]  dir_mode;

   logic        sid_ok, here;

   function automatic logic pend(input logic [15:0] m, input logic [4:0] n,
                                 input logic [4:0] s);
      logic [4:0] sm1;
      sm1 = s - 5'd1;
      return (s != 5'd0) && (s <= n) && m[sm1[3:0]];
   endfunction

   // clamped configuration
   always_comb begin
      if (num_ff < 5'd2) nc = 5'd2;
      else if (num_ff > 5'(rrsd_pkg::MAX_STATIONS)) nc = 5'(rrsd_pkg::MAX_STATIONS);
      else nc = num_ff;
      if (spc_ff < 5'd1) spc = 5'd1;
      else if (spc_ff > 5'(rrsd_pkg::MAX_SPACING)) spc = 5'(rrsd_pkg::MAX_SPACING);
      else spc = spc_ff;
   end

   assign len_full    = {5'd0, nc} * {5'd0, spc};
   assign len         = len_full[8:0];
   assign half_n      = nc >> 1;
   assign st          = {1'b0, quo_ff[3:0]} + 5'd1;
   assign pend_mask   = cw_ff | ccw_ff | stop_ff;
   assign ring_mask_w = (17'd1 << nc) - 17'd1;
   assign ring_mask   = ring_mask_w[15:0];
   assign any_pend    = |(pend_mask & ring_mask);

   assign div_cand = {rem_ff, pos_ff[3'd7 - cnt_ff]};
   assign div_bit  = (div_cand >= {1'b0, spc});

   // one position step, station index and offset kept alongside
   always_comb begin
      mv_pos = pos_ff;
      mv_quo = quo_ff;
      mv_rem = rem_ff;
      if (mv_dir == rrsd_pkg::MODE_DEC) begin
         if (pos_ff == 8'd0) begin
            mv_pos = 8'(len - 9'd1);
            mv_quo = {3'd0, nc - 5'd1};
            mv_rem = spc - 5'd1;
         end else if (rem_ff == 5'd0) begin
            mv_pos = pos_ff - 8'd1;
            mv_quo = quo_ff - 8'd1;
            mv_rem = spc - 5'd1;
         end else begin
            mv_pos = pos_ff - 8'd1;
            mv_rem = rem_ff - 5'd1;
         end
      end else begin
         if (({1'b0, pos_ff} + 9'd1) >= len) begin
            mv_pos = 8'd0;
            mv_quo = 8'd0;
            mv_rem = 5'd0;
         end else if (rem_ff == spc - 5'd1) begin
            mv_pos = pos_ff + 8'd1;
            mv_quo = quo_ff + 8'd1;
            mv_rem = 5'd0;
         end else begin
            mv_pos = pos_ff + 8'd1;
            mv_rem = rem_ff + 5'd1;
         end
      end
      mv_park = (mv_rem == 5'd0) && pend(pend_mask, nc, {1'b0, mv_quo[3:0]} + 5'd1);
   end

   // station walker: next station in the travel direction, and the nearest pair
   always_comb begin
      if (prior_ff == rrsd_pkg::MODE_DEC) t_nx = (t_ff <= 5'd1) ? nc : t_ff - 5'd1;
      else t_nx = (t_ff >= nc) ? 5'd1 : t_ff + 5'd1;
      a_sum = {2'd0, quo_ff[3:0]} + {2'd0, d_ff};
      b_sum = {2'd0, quo_ff[3:0]} + {1'b0, nc} - {2'd0, d_ff};
      a_red = (a_sum >= {1'b0, nc}) ? a_sum - {1'b0, nc} : a_sum;
      b_red = (b_sum >= {1'b0, nc}) ? b_sum - {1'b0, nc} : b_sum;
      a_st  = a_red[4:0] + 5'd1;
      b_st  = b_red[4:0] + 5'd1;
   end

   // goal within half a ring clockwise from the current station
   always_comb begin
      e_sum = {2'd0, quo_ff[3:0]} + {1'b0, half_n};
      e_red = (e_sum >= {1'b0, nc}) ? e_sum - {1'b0, nc} : e_sum;
      e_st  = e_red[4:0] + 5'd1;
      if (e_st > st) cw_half = (st <= goal_ff) && (goal_ff <= e_st);
      else cw_half = ((st <= goal_ff) && (goal_ff <= nc))
                     || ((goal_ff >= 5'd1) && (goal_ff <= e_st));
      dir_mode = cw_half ? rrsd_pkg::MODE_INC : rrsd_pkg::MODE_DEC;
   end

   assign mv_dir = (state_ff == S_DIRSET) ? dir_mode : mode_ff;

   assign sid_ok = (sid_ff >= 5'd1) && (sid_ff <= nc);
   assign here   = (rem_ff == 5'd0)
                   && ((mode_ff == rrsd_pkg::MODE_STOP) || (mode_ff == rrsd_pkg::MODE_IDLE))
                   && (sid_ff == st);

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      ticks_in = ticks_ff;
      pos_in   = pos_ff;
      mode_in  = mode_ff;
      prior_in = prior_ff;
      goal_in  = goal_ff;
      cw_in    = cw_ff;
      ccw_in   = ccw_ff;
      stop_in  = stop_ff;
      kind_in  = kind_ff;
      sid_in   = sid_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      path_in  = path_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      d_in     = d_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in  = req_chan.req_type;
               sid_in   = req_chan.station_id;
               pos_in   = ({1'b0, pos_ff} >= len) ? 8'd0 : pos_ff;
               quo_in   = 8'd0;
               rem_in   = 5'd0;
               cnt_in   = 3'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = div_bit ? 5'(div_cand - {1'b0, spc}) : div_cand[4:0];
            quo_in = {quo_ff[6:0], div_bit};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (kind_ff != rrsd_pkg::REQ_TICK) begin
               if (sid_ok && !here) begin
                  case (kind_ff)
                     rrsd_pkg::REQ_CCW: ccw_in[sid_ff[3:0] - 4'd1] = 1'b1;
                     rrsd_pkg::REQ_CW:  cw_in[sid_ff[3:0] - 4'd1]  = 1'b1;
                     default:           stop_in[sid_ff[3:0] - 4'd1] = 1'b1;
                  endcase
               end
               state_in = S_RESP;
            end else begin
               ticks_in = ticks_ff + 32'd1;
               unique case (mode_ff)
                  rrsd_pkg::MODE_IDLE: begin
                     path_in  = 1'b0;
                     state_in = S_CHOOSE;
                  end
                  rrsd_pkg::MODE_STOP: begin
                     cw_in[quo_ff[3:0]]   = 1'b0;
                     ccw_in[quo_ff[3:0]]  = 1'b0;
                     stop_in[quo_ff[3:0]] = 1'b0;
                     if (st == goal_ff) begin
                        path_in  = 1'b1;
                        state_in = S_CHOOSE;
                     end else begin
                        mode_in  = prior_ff;
                        prior_in = rrsd_pkg::MODE_STOP;
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     prior_in = mode_ff;
                     pos_in   = mv_pos;
                     quo_in   = mv_quo;
                     rem_in   = mv_rem;
                     if (mv_park) mode_in = rrsd_pkg::MODE_STOP;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_CHOOSE: begin
            goal_in = 5'd0;
            if (!any_pend) begin
               mode_in  = rrsd_pkg::MODE_IDLE;
               prior_in = path_ff ? rrsd_pkg::MODE_STOP : rrsd_pkg::MODE_IDLE;
               state_in = S_RESP;
            end else if ((prior_ff == rrsd_pkg::MODE_DEC)
                         || (prior_ff == rrsd_pkg::MODE_INC)) begin
               t_in     = st;
               k_in     = 5'd0;
               state_in = S_SCAN;
            end else begin
               d_in     = 4'd1;
               state_in = S_NEAR;
            end
         end
         S_SCAN: begin
            t_in = t_nx;
            k_in = k_ff + 5'd1;
            if (pend(pend_mask, nc, t_nx)) begin
               goal_in  = t_nx;
               state_in = S_DIRSET;
            end else if (k_ff == nc - 5'd1) begin
               d_in     = 4'd1;
               state_in = S_NEAR;
            end
         end
         S_NEAR: begin
            d_in = d_ff + 4'd1;
            if (pend(pend_mask, nc, a_st)) begin
               goal_in  = a_st;
               state_in = S_DIRSET;
            end else if (pend(pend_mask, nc, b_st)) begin
               goal_in  = b_st;
               state_in = S_DIRSET;
            end else if ({1'b0, d_ff} == half_n) begin
               state_in = S_DIRSET;   // requests only at this station: goal stays none
            end
         end
         S_DIRSET: begin
            mode_in  = dir_mode;
            prior_in = path_ff ? rrsd_pkg::MODE_STOP : dir_mode;
            if (!path_ff) begin
               pos_in = mv_pos;
               quo_in = mv_quo;
               rem_in = mv_rem;
               if (mv_park) mode_in = rrsd_pkg::MODE_STOP;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ff       <= rrsd_pkg::NUM_STATIONS_RST;
         spc_ff       <= rrsd_pkg::STOP_SPACING_RST;
         ticks_ff     <= '0;
         pos_ff       <= '0;
         mode_ff      <= rrsd_pkg::MODE_IDLE;
         prior_ff     <= rrsd_pkg::MODE_IDLE;
         goal_ff      <= '0;
         cw_ff        <= '0;
         ccw_ff       <= '0;
         stop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         prior_ff     <= prior_in;
         goal_ff      <= goal_in;
         cw_ff        <= cw_in;
         ccw_ff       <= ccw_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               rrsd_pkg::CSR_NUM_STATIONS: num_ff <= csr_wr_data;
               rrsd_pkg::CSR_STOP_SPACING: spc_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sid_ff  <= sid_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      path_ff <= path_in;
      t_ff    <= t_in;
      k_ff    <= k_in;
      d_ff    <= d_in;
      if (rsp_load) begin
         rsp_ticks_ff <= ticks_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_mode_ff  <= mode_ff;
         rsp_goal_ff  <= goal_ff;
         rsp_stop_ff  <= stop_ff;
         rsp_cw_ff    <= cw_ff;
         rsp_ccw_ff   <= ccw_ff;
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_ticks     = rsp_ticks_ff;
   assign rsp_chan.out_position  = rsp_pos_ff;
   assign rsp_chan.out_mode      = rsp_mode_ff;
   assign rsp_chan.out_goal      = rsp_goal_ff;
   assign rsp_chan.out_stop_mask = rsp_stop_ff;
   assign rsp_chan.out_cw_mask   = rsp_cw_ff;
   assign rsp_chan.out_ccw_mask  = rsp_ccw_ff;

endmodule

// ===== test/rrsd_status_checker.sv =====
// ---------------------------------------------------------------------------
// rrsd_status_checker: status predictor and scoreboard for the ring dispatcher
// Watches the request, status and CSR ports, keeps its own copy of the vehicle
// state, predicts one status per accepted request and compares it in order.
// ---------------------------------------------------------------------------
module rrsd_status_checker (
   input  logic                              clock,
   input  logic                              reset,
   rrsd_req_if                               req_chan,
   rrsd_rsp_if                               rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rrsd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rrsd_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output int                                fail_count,
   output int                                pending_count,
   output int                                checked_count
);

   typedef struct packed {
      logic [rrsd_pkg::TICKS_W-1:0]   ticks;
      logic [rrsd_pkg::POS_W-1:0]     position;
      logic [rrsd_pkg::MODE_W-1:0]    mode;
      logic [rrsd_pkg::STATION_W-1:0] goal;
      logic [rrsd_pkg::MASK_W-1:0]    stop_mask;
      logic [rrsd_pkg::MASK_W-1:0]    cw_mask;
      logic [rrsd_pkg::MASK_W-1:0]    ccw_mask;
   } status_type;

   status_type status_q[$];

   logic [rrsd_pkg::CSR_DATA_W-1:0] cfg_n;
   logic [rrsd_pkg::CSR_DATA_W-1:0] cfg_sp;

   logic [rrsd_pkg::TICKS_W-1:0]    tick_total;
   logic [rrsd_pkg::POS_W-1:0]      veh_pos;
   logic [rrsd_pkg::MODE_W-1:0]     veh_mode;
   logic [rrsd_pkg::MODE_W-1:0]     prev_mode;
   logic [rrsd_pkg::STATION_W-1:0]  goal_stn;
   logic [rrsd_pkg::MASK_W-1:0]     cw_pending;
   logic [rrsd_pkg::MASK_W-1:0]     ccw_pending;
   logic [rrsd_pkg::MASK_W-1:0]     stop_pending;

   int mismatches = 0;
   int checked    = 0;

   assign fail_count    = mismatches;
   assign checked_count = checked;

   function automatic int ring_count();
      if (cfg_n < 2) return 2;
      if (cfg_n > rrsd_pkg::MAX_STATIONS) return rrsd_pkg::MAX_STATIONS;
      return int'(cfg_n);
   endfunction

   function automatic int ring_gap();
      if (cfg_sp < 1) return 1;
      if (cfg_sp > rrsd_pkg::MAX_SPACING) return rrsd_pkg::MAX_SPACING;
      return int'(cfg_sp);
   endfunction

   // bits beyond the active ring never count as a call
   function automatic logic call_at(int s);
      logic [rrsd_pkg::MASK_W-1:0] merged;
      merged = cw_pending | ccw_pending | stop_pending;
      if (s < 1 || s > ring_count()) return 1'b0;
      return merged[s-1];
   endfunction

   function automatic logic calls_on_ring();
      for (int s = 1; s <= ring_count(); s++)
         if (call_at(s)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void clear_station(int s);
      if (s < 1 || s > rrsd_pkg::MASK_W) return;
      cw_pending[s-1]   = 1'b0;
      ccw_pending[s-1]  = 1'b0;
      stop_pending[s-1] = 1'b0;
   endfunction

   // dst within half a ring going clockwise from src
   function automatic logic half_ring_cw(int src, int dst);
      int n;
      int far;
      n   = ring_count();
      far = ((src - 1) + n / 2) % n + 1;
      if (far > src) return (src <= dst) && (dst <= far);
      return ((src <= dst) && (dst <= n)) || ((1 <= dst) && (dst <= far));
   endfunction

   function automatic void seek_nearest(int st);
      int n;
      int a;
      int b;
      n = ring_count();
      for (int d = 1; d <= n / 2; d++) begin
         a = (st - 1 + d) % n + 1;
         b = (st - 1 + n - d) % n + 1;
         if (call_at(a)) begin
            goal_stn = rrsd_pkg::STATION_W'(a);
            return;
         end
         if (call_at(b)) begin
            goal_stn = rrsd_pkg::STATION_W'(b);
            return;
         end
      end
   endfunction

   function automatic void select_goal(int st);
      int n;
      int t;
      logic found;
      n        = ring_count();
      t        = st;
      found    = 1'b0;
      goal_stn = '0;
      if (!calls_on_ring()) begin
         veh_mode = rrsd_pkg::MODE_IDLE;
         return;
      end
      // keep sweeping the way we were heading
      if (prev_mode == rrsd_pkg::MODE_DEC || prev_mode == rrsd_pkg::MODE_INC) begin
         for (int k = 0; k < n && !found; k++) begin
            if (prev_mode == rrsd_pkg::MODE_DEC) t = (t <= 1) ? n : t - 1;
            else t = (t >= n) ? 1 : t + 1;
            if (call_at(t)) begin
               goal_stn = rrsd_pkg::STATION_W'(t);
               found    = 1'b1;
            end
         end
      end
      if (goal_stn == 0) seek_nearest(st);
      veh_mode = half_ring_cw(st, int'(goal_stn)) ? rrsd_pkg::MODE_INC : rrsd_pkg::MODE_DEC;
   endfunction

   function automatic void step_vehicle(logic [rrsd_pkg::MODE_W-1:0] dir);
      int sp;
      int len;
      int p;
      sp  = ring_gap();
      len = ring_count() * sp;
      p   = int'(veh_pos);
      if (dir == rrsd_pkg::MODE_DEC) p = (p == 0) ? len - 1 : p - 1;
      else p = (p + 1 >= len) ? 0 : p + 1;
      veh_pos = rrsd_pkg::POS_W'(p);
      if (p % sp == 0 && call_at(p / sp + 1)) begin
         prev_mode = dir;
         veh_mode  = rrsd_pkg::MODE_STOP;
      end
   endfunction

   function automatic void run_tick();
      int st;
      st         = int'(veh_pos) / ring_gap() + 1;
      tick_total = tick_total + 1;
      case (veh_mode)
         rrsd_pkg::MODE_IDLE: begin
            select_goal(st);
            prev_mode = rrsd_pkg::MODE_IDLE;
            if (veh_mode == rrsd_pkg::MODE_DEC || veh_mode == rrsd_pkg::MODE_INC) begin
               prev_mode = veh_mode;
               step_vehicle(veh_mode);
            end
         end
         rrsd_pkg::MODE_STOP: begin
            clear_station(st);
            if (st == int'(goal_stn)) select_goal(st);
            else veh_mode = prev_mode;
            prev_mode = rrsd_pkg::MODE_STOP;
         end
         default: begin
            prev_mode = veh_mode;
            step_vehicle(veh_mode);
         end
      endcase
   endfunction

   function automatic status_type predict_status(logic [rrsd_pkg::REQ_TYPE_W-1:0] kind,
                                                 logic [rrsd_pkg::STATION_W-1:0] sid);
      int n;
      int sp;
      int s;
      int p;
      status_type r;
      n  = ring_count();
      sp = ring_gap();
      s  = int'(sid);
      // position left past a shrunken ring folds back to station one
      if (int'(veh_pos) >= n * sp) veh_pos = '0;
      p = int'(veh_pos);
      if (kind == rrsd_pkg::REQ_TICK) begin
         run_tick();
      end else if (s >= 1 && s <= n) begin
         if (!((p % sp == 0)
               && (veh_mode == rrsd_pkg::MODE_STOP || veh_mode == rrsd_pkg::MODE_IDLE)
               && (s == p / sp + 1))) begin
            case (kind)
               rrsd_pkg::REQ_CCW: ccw_pending[s-1]  = 1'b1;
               rrsd_pkg::REQ_CW:  cw_pending[s-1]   = 1'b1;
               default:           stop_pending[s-1] = 1'b1;
            endcase
         end
      end
      r.ticks     = tick_total;
      r.position  = veh_pos;
      r.mode      = veh_mode;
      r.goal      = goal_stn;
      r.stop_mask = stop_pending;
      r.cw_mask   = cw_pending;
      r.ccw_mask  = ccw_pending;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      status_type seen;
      status_type want;
      if (reset) begin
         cfg_n        = rrsd_pkg::NUM_STATIONS_RST;
         cfg_sp       = rrsd_pkg::STOP_SPACING_RST;
         tick_total   = '0;
         veh_pos      = '0;
         veh_mode     = rrsd_pkg::MODE_IDLE;
         prev_mode    = rrsd_pkg::MODE_IDLE;
         goal_stn     = '0;
         cw_pending   = '0;
         ccw_pending  = '0;
         stop_pending = '0;
         status_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               rrsd_pkg::CSR_NUM_STATIONS: cfg_n  = csr_wr_data;
               default:                    cfg_sp = csr_wr_data;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.ticks     = rsp_chan.out_ticks;
            seen.position  = rsp_chan.out_position;
            seen.mode      = rsp_chan.out_mode;
            seen.goal      = rsp_chan.out_goal;
            seen.stop_mask = rsp_chan.out_stop_mask;
            seen.cw_mask   = rsp_chan.out_cw_mask;
            seen.ccw_mask  = rsp_chan.out_ccw_mask;
            if (status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] status with no request outstanding: ticks=%0d pos=%0d",
                           $realtime, seen.ticks, seen.position);
            end else begin
               want = status_q.pop_front();
               checked++;
               if (seen.ticks !== want.ticks || seen.position !== want.position ||
                   seen.mode !== want.mode || seen.goal !== want.goal ||
                   seen.stop_mask !== want.stop_mask || seen.cw_mask !== want.cw_mask ||
                   seen.ccw_mask !== want.ccw_mask) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] status %0d mismatch", $realtime, checked);
                     $display("   expected ticks=%0d pos=%0d mode=%0d goal=%0d stop=%h cw=%h ccw=%h",
                              want.ticks, want.position, want.mode, want.goal,
                              want.stop_mask, want.cw_mask, want.ccw_mask);
                     $display("   actual   ticks=%0d pos=%0d mode=%0d goal=%0d stop=%h cw=%h ccw=%h",
                              seen.ticks, seen.position, seen.mode, seen.goal,
                              seen.stop_mask, seen.cw_mask, seen.ccw_mask);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            status_q.push_back(predict_status(req_chan.req_type, req_chan.station_id));
      end
      pending_count <= status_q.size();
   end

endmodule

// ===== test/ring_route_scan_dispatcher_unit_tb.sv =====
// ---------------------------------------------------------------------------
// ring_route_scan_dispatcher_unit_tb: top of the ring dispatcher testbench
// Drives requests and ring settings with random sender gaps and status stalls;
// the status checker beside the block predicts and compares every status.
// ---------------------------------------------------------------------------
module ring_route_scan_dispatcher_unit_tb;

   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int CYCLE_LIMIT     = 400000;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [rrsd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rrsd_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   int fail_count;
   int pending_count;
   int checked_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int ring_n_used   = int'(rrsd_pkg::NUM_STATIONS_RST);
   int items_sent    = 0;
   int ticks_sent    = 0;
   int settings_used = 0;
   int cycle_cnt     = 0;

   // ring settings per phase, extremes included; raw values clamp in the block
   logic [rrsd_pkg::CSR_DATA_W-1:0] phase_n  [PHASES] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd9};
   logic [rrsd_pkg::CSR_DATA_W-1:0] phase_sp [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3};
   int phase_gap   [PHASES] = '{0, 53, 0, 16, 0};
   int phase_stall [PHASES] = '{0, 0, 53, 16, 0};

   rrsd_req_if req_if ();
   rrsd_rsp_if rsp_if ();

   ring_route_scan_dispatcher_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rrsd_status_checker i_status_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_if),
      .rsp_chan      (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d statuses outstanding",
                  cycle_cnt, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(input logic [rrsd_pkg::REQ_TYPE_W-1:0] kind,
                               input logic [rrsd_pkg::STATION_W-1:0]  sid);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.station_id <= sid;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (kind == rrsd_pkg::REQ_TICK) ticks_sent++;
   endtask

   // mostly ticks and calls on the active ring, some ids anywhere in the field
   task automatic random_request();
      logic [rrsd_pkg::REQ_TYPE_W-1:0] kind;
      logic [rrsd_pkg::STATION_W-1:0]  sid;
      if ($urandom_range(99) < 65) begin
         kind = rrsd_pkg::REQ_TICK;
      end else begin
         case ($urandom_range(2))
            0:       kind = rrsd_pkg::REQ_CCW;
            1:       kind = rrsd_pkg::REQ_CW;
            default: kind = rrsd_pkg::REQ_STOP;
         endcase
      end
      if ($urandom_range(99) < 88)
         sid = rrsd_pkg::STATION_W'($urandom_range(ring_n_used, 1));
      else sid = rrsd_pkg::STATION_W'($urandom_range(31));
      send_request(kind, sid);
   endtask

   // wait until every predicted status has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ring(input logic [rrsd_pkg::CSR_DATA_W-1:0] n,
                           input logic [rrsd_pkg::CSR_DATA_W-1:0] sp);
      csr_wr_en   <= 1'b1;
      csr_index   <= rrsd_pkg::CSR_NUM_STATIONS;
      csr_wr_data <= n;
      @(posedge clock);
      csr_index   <= rrsd_pkg::CSR_STOP_SPACING;
      csr_wr_data <= sp;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ring_n_used = (n < 2) ? 2
                  : (n > rrsd_pkg::MAX_STATIONS) ? rrsd_pkg::MAX_STATIONS : int'(n);
      settings_used++;
   endtask

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = rrsd_pkg::CSR_NUM_STATIONS;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.req_type   = rrsd_pkg::REQ_TICK;
      req_if.station_id = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // own station while idle, station zero, past the ring, high id bit
      send_request(rrsd_pkg::REQ_CW, 5'd1);
      send_request(rrsd_pkg::REQ_CCW, 5'd0);
      send_request(rrsd_pkg::REQ_STOP, 5'd6);
      send_request(rrsd_pkg::REQ_CW, 5'd31);
      send_request(rrsd_pkg::REQ_CW, 5'd3);
      send_request(rrsd_pkg::REQ_CCW, 5'd5);
      send_request(rrsd_pkg::REQ_STOP, 5'd2);
      repeat (12) send_request(rrsd_pkg::REQ_TICK, 5'd0);
      send_request(rrsd_pkg::REQ_STOP, 5'd1);
      send_request(rrsd_pkg::REQ_STOP, 5'd16);
      drain();
      // both registers below their floor: position folds back, upper bits go stale
      set_ring(5'd0, 5'd0);
      send_request(rrsd_pkg::REQ_CW, 5'd2);
      repeat (3) send_request(rrsd_pkg::REQ_TICK, 5'd31);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         set_ring(phase_n[ph], phase_sp[ph]);
         send_idle_pct = phase_gap[ph];
         stall_pct     = phase_stall[ph];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (ph == 1 && i == ITEMS_PER_PHASE / 2) drain();
            random_request();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests (%0d ticks) over %0d ring settings; %0d statuses checked",
               items_sent, ticks_sent, settings_used, checked_count);
      $display("Sender gaps and status stalls up to 53 percent, plus a full drain mid-phase");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
